@@ rtl/srs_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// srs_pkg
// Shared constants, codes and types of the selective-repeat sender.
// ============================================================================
package srs_pkg;

    localparam int WINDOW_SLOTS  = 6;
    localparam int SEQ_SPACE     = 12;
    localparam int PAYLOAD_WORDS = 5;
    localparam int RAM_DEPTH     = WINDOW_SLOTS * PAYLOAD_WORDS;

    localparam int SLOT_W = 3;
    localparam int SEQ_W  = 4;
    localparam int WIDX_W = 3;
    localparam int SUM_W  = 13;
    localparam int ADDR_W = 5;
    localparam int WORD_W = 32;

    // input function codes
    localparam logic [1:0] FUNC_MSG     = 2'd0;
    localparam logic [1:0] FUNC_ACK     = 2'd1;
    localparam logic [1:0] FUNC_TIMEOUT = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_SENT = 2'd0;
    localparam logic [1:0] KIND_DROP = 2'd1;
    localparam logic [1:0] KIND_ACK  = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_SEND,
        ST_SCAN,
        ST_ACK_CHECK,
        ST_ACK_SLIDE
    } state_t;

    // slot table update command
    typedef struct packed {
        logic              commit;
        logic              mark;
        logic              clear;
        logic [SLOT_W-1:0] idx;
        logic [SEQ_W-1:0]  seq;
        logic [SUM_W-1:0]  sum;
    } slot_cmd_t;

    // slot table status
    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] hit_idx;
        logic              hit_acked;
        logic              free_ok;
        logic [SLOT_W-1:0] free_idx;
        logic              more;
        logic [SEQ_W-1:0]  rd_seq;
        logic [SUM_W-1:0]  rd_sum;
    } slot_stat_t;

    // result waiting for its payload word from the store
    typedef struct packed {
        logic             valid;
        logic [1:0]       kind;
        logic [SEQ_W-1:0] seq;
        logic [SUM_W-1:0] sum;
        logic             use_word;
        logic             last;
        logic             tstart;
        logic             tstop;
        logic             corrupted;
    } pend_t;

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [SLOT_W-1:0] slot,
                                                    input logic [WIDX_W-1:0] idx);
        slot_addr = ADDR_W'(slot) * ADDR_W'(PAYLOAD_WORDS) + ADDR_W'(idx);
    endfunction

endpackage

@@ rtl/srs_ram.sv @@
`timescale 1ns / 1ps
// ============================================================================
// srs_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module srs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 30
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ rtl/srs_sum_unit.sv @@
`timescale 1ns / 1ps
// ============================================================================
// srs_sum_unit
// Shared checksum adder: a + b + c + signed bytes of word, wrapped to 13 bits.
// ============================================================================
module srs_sum_unit (
    input  logic [srs_pkg::SUM_W-1:0]  a,
    input  logic [srs_pkg::SUM_W-1:0]  b,
    input  logic [srs_pkg::SUM_W-1:0]  c,
    input  logic [srs_pkg::WORD_W-1:0] word,
    output logic [srs_pkg::SUM_W-1:0]  sum
);

    logic [srs_pkg::SUM_W-1:0] bytes_sum;

    // sign-extended byte sum
    always_comb
    begin
        bytes_sum = '0;
        for (int i = 0; i < 4; i++)
        begin
            bytes_sum = bytes_sum + {{(srs_pkg::SUM_W-8){word[8*i+7]}}, word[8*i +: 8]};
        end
    end

    assign sum = a + b + c + bytes_sum;

endmodule

@@ rtl/srs_slot_table.sv @@
`timescale 1ns / 1ps
// ============================================================================
// srs_slot_table
// Window slot registers with sequence lookup, free search and pending scan.
// ============================================================================
module srs_slot_table (
    input  logic                       clk,
    input  logic                       rst_n,
    input  srs_pkg::slot_cmd_t         cmd,
    input  logic [srs_pkg::SEQ_W-1:0]  key,
    input  logic [srs_pkg::SLOT_W-1:0] rd_idx,
    input  logic [srs_pkg::SEQ_W-1:0]  base,
    input  logic [srs_pkg::SEQ_W-1:0]  off,
    output srs_pkg::slot_stat_t        stat
);

    logic [srs_pkg::SEQ_W-1:0] seq_reg   [srs_pkg::WINDOW_SLOTS];
    logic [srs_pkg::SUM_W-1:0] sum_reg   [srs_pkg::WINDOW_SLOTS];
    logic [srs_pkg::WINDOW_SLOTS-1:0] sent_reg;
    logic [srs_pkg::WINDOW_SLOTS-1:0] acked_reg;
    logic [srs_pkg::SEQ_W-1:0] gap [srs_pkg::WINDOW_SLOTS];

    // control bits and sequence numbers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_reg  <= '0;
            acked_reg <= '0;
            for (int i = 0; i < srs_pkg::WINDOW_SLOTS; i++)
            begin
                seq_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.commit)
            begin
                seq_reg[cmd.idx]   <= cmd.seq;
                sent_reg[cmd.idx]  <= 1'b1;
                acked_reg[cmd.idx] <= 1'b0;
            end
            if (cmd.mark)
            begin
                acked_reg[cmd.idx] <= 1'b1;
            end
            if (cmd.clear)
            begin
                sent_reg[cmd.idx]  <= 1'b0;
                acked_reg[cmd.idx] <= 1'b0;
            end
        end
    end

    // checksums, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            sum_reg[cmd.idx] <= cmd.sum;
        end
    end

    // distance of each slot from the window base
    always_comb
    begin
        for (int i = 0; i < srs_pkg::WINDOW_SLOTS; i++)
        begin
            if (seq_reg[i] >= base)
            begin
                gap[i] = seq_reg[i] - base;
            end
            else
            begin
                gap[i] = srs_pkg::SEQ_W'(seq_reg[i] + srs_pkg::SEQ_W'(srs_pkg::SEQ_SPACE) - base);
            end
        end
    end

    // lookup, free search, pending-later flag
    always_comb
    begin
        stat = '0;
        for (int i = srs_pkg::WINDOW_SLOTS - 1; i >= 0; i--)
        begin
            if (sent_reg[i] && seq_reg[i] == key)
            begin
                stat.hit       = 1'b1;
                stat.hit_idx   = srs_pkg::SLOT_W'(i);
                stat.hit_acked = acked_reg[i];
            end
            if (!sent_reg[i])
            begin
                stat.free_ok  = 1'b1;
                stat.free_idx = srs_pkg::SLOT_W'(i);
            end
            if (sent_reg[i] && !acked_reg[i] && gap[i] > off)
            begin
                stat.more = 1'b1;
            end
        end
        stat.rd_seq = seq_reg[rd_idx];
        stat.rd_sum = sum_reg[rd_idx];
    end

endmodule

@@ rtl/selective_repeat_sender_unit.sv @@
`timescale 1ns / 1ps
// ============================================================================
// selective_repeat_sender_unit
// Sender side of a selective-repeat ARQ link with a six-slot window.
// ============================================================================
// Usage:
//   Input channel: present func, payload_word, word_last and the ack fields
//   with start high; the item is taken at an edge where busy is low.
//   Message and ack words before the last are taken in idle. The last word
//   of a message leads through fill (zeroing the words not stored), a
//   commit step and the send of five words. A closing ack word goes to a
//   check step; a valid ack then slides the window over each acked packet
//   at the base (up to 6) and closes. A timeout walks up to 12 sequence
//   numbers, one per cycle between resends, resending five words per packet.
//   The rate is set by the payload store, read one word a cycle.
//   Results: out_valid strobes one cycle per result; kind, seqnum,
//   checksum, out_word and the flags are valid with it. A result passes
//   through pend_reg and then the output registers; the words of one packet
//   come back to back, a timeout leaves scan cycles between packets, and
//   results always come in item order. The receiver cannot stall.
//   Reset empties the window, stops the timer and zeroes the counters; the
//   payload store needs no clearing.
// ============================================================================
module selective_repeat_sender_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         func,
    input  logic [31:0]        payload_word,
    input  logic               word_last,
    input  logic signed [4:0]  ack_seqnum,
    input  logic signed [4:0]  ack_number,
    input  logic signed [12:0] ack_checksum,
    output logic               out_valid,
    output logic [1:0]         kind,
    output logic [3:0]         seqnum,
    output logic signed [12:0] checksum,
    output logic [31:0]        out_word,
    output logic               last,
    output logic               timer_start,
    output logic               timer_stop,
    output logic               corrupted
);

    srs_pkg::state_t state_reg, state_next;

    logic [srs_pkg::WIDX_W-1:0] wi_reg, wi_next;
    logic [srs_pkg::SUM_W-1:0]  acc_reg, acc_next;
    logic [srs_pkg::SEQ_W-1:0]  base_reg, base_next;
    logic [srs_pkg::SEQ_W-1:0]  next_seq_reg, next_seq_next;
    logic                       timer_run_reg, timer_run_next;
    logic [srs_pkg::SEQ_W-1:0]  timer_seq_reg, timer_seq_next;
    logic [srs_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic [srs_pkg::WIDX_W-1:0] widx_reg, widx_next;
    logic                       send_last_reg, send_last_next;
    logic                       tstart_reg, tstart_next;
    logic [srs_pkg::SEQ_W-1:0]  off_reg, off_next;
    logic                       found_reg, found_next;
    logic                       stop_reg, stop_next;
    logic [4:0]                 ack_seq_reg, ack_seq_next;
    logic [4:0]                 ack_num_reg, ack_num_next;
    logic [srs_pkg::SUM_W-1:0]  ack_chk_reg, ack_chk_next;
    srs_pkg::pend_t             pend_reg, pend_next;

    logic                       accept;
    logic                       word_room;
    logic                       chk_ok;
    logic                       ack_valid;
    logic                       send_done;
    logic                       scan_hit;
    logic                       scan_end;
    logic [4:0]                 scan_sum;
    logic [srs_pkg::SEQ_W-1:0]  scan_seq;

    logic [srs_pkg::SUM_W-1:0]  unit_a, unit_b, unit_c, unit_sum;
    logic [srs_pkg::WORD_W-1:0] unit_word;

    srs_pkg::slot_cmd_t         tbl_cmd;
    srs_pkg::slot_stat_t        tbl_stat;
    logic [srs_pkg::SEQ_W-1:0]  tbl_key;

    logic                       ram_we;
    logic [srs_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [srs_pkg::WORD_W-1:0] ram_wdata, ram_rdata;

    srs_sum_unit u_sum (
        .a    (unit_a),
        .b    (unit_b),
        .c    (unit_c),
        .word (unit_word),
        .sum  (unit_sum)
    );

    srs_slot_table u_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (tbl_cmd),
        .key    (tbl_key),
        .rd_idx (slot_reg),
        .base   (base_reg),
        .off    (off_reg),
        .stat   (tbl_stat)
    );

    srs_ram #(
        .WIDTH (srs_pkg::WORD_W),
        .DEPTH (srs_pkg::RAM_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // common conditions
    assign busy      = (state_reg != srs_pkg::ST_IDLE);
    assign accept    = start && !busy;
    assign word_room = (wi_reg < srs_pkg::WIDX_W'(srs_pkg::PAYLOAD_WORDS));
    assign chk_ok    = (unit_sum == ack_chk_reg);
    assign ack_valid = chk_ok && !ack_num_reg[4] && tbl_stat.hit;
    assign send_done = (widx_reg == srs_pkg::WIDX_W'(srs_pkg::PAYLOAD_WORDS - 1));
    assign scan_hit  = tbl_stat.hit && !tbl_stat.hit_acked;
    assign scan_end  = (off_reg == srs_pkg::SEQ_W'(srs_pkg::SEQ_SPACE - 1));
    assign scan_sum  = {1'b0, base_reg} + {1'b0, off_reg};
    assign scan_seq  = (scan_sum >= 5'(srs_pkg::SEQ_SPACE))
                     ? srs_pkg::SEQ_W'(scan_sum - 5'(srs_pkg::SEQ_SPACE))
                     : srs_pkg::SEQ_W'(scan_sum);

    // table lookup key
    always_comb
    begin
        unique case (state_reg)
            srs_pkg::ST_ACK_CHECK: tbl_key = ack_num_reg[3:0];
            srs_pkg::ST_SCAN:      tbl_key = scan_seq;
            default:               tbl_key = base_reg;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            srs_pkg::ST_IDLE:
            begin
                if (accept && word_last && func == srs_pkg::FUNC_MSG && tbl_stat.free_ok)
                begin
                    state_next = srs_pkg::ST_FILL;
                end
                else if (accept && word_last && func == srs_pkg::FUNC_ACK)
                begin
                    state_next = srs_pkg::ST_ACK_CHECK;
                end
                else if (accept && func == srs_pkg::FUNC_TIMEOUT)
                begin
                    state_next = srs_pkg::ST_SCAN;
                end
            end
            srs_pkg::ST_FILL:
            begin
                if (!word_room)
                begin
                    state_next = srs_pkg::ST_SEND;
                end
            end
            srs_pkg::ST_SEND:
            begin
                if (send_done)
                begin
                    state_next = send_last_reg ? srs_pkg::ST_IDLE : srs_pkg::ST_SCAN;
                end
            end
            srs_pkg::ST_SCAN:
            begin
                if (scan_hit)
                begin
                    state_next = srs_pkg::ST_SEND;
                end
                else if (scan_end)
                begin
                    state_next = srs_pkg::ST_IDLE;
                end
            end
            srs_pkg::ST_ACK_CHECK:
            begin
                state_next = ack_valid ? srs_pkg::ST_ACK_SLIDE : srs_pkg::ST_IDLE;
            end
            srs_pkg::ST_ACK_SLIDE:
            begin
                if (!(tbl_stat.hit && tbl_stat.hit_acked))
                begin
                    state_next = srs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = srs_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and results
    always_comb
    begin
        wi_next        = wi_reg;
        acc_next       = acc_reg;
        base_next      = base_reg;
        next_seq_next  = next_seq_reg;
        timer_run_next = timer_run_reg;
        timer_seq_next = timer_seq_reg;
        slot_next      = slot_reg;
        widx_next      = widx_reg;
        send_last_next = send_last_reg;
        tstart_next    = tstart_reg;
        off_next       = off_reg;
        found_next     = found_reg;
        stop_next      = stop_reg;
        ack_seq_next   = ack_seq_reg;
        ack_num_next   = ack_num_reg;
        ack_chk_next   = ack_chk_reg;
        pend_next      = '0;
        tbl_cmd        = '0;
        ram_we         = 1'b0;
        ram_waddr      = srs_pkg::slot_addr(tbl_stat.free_idx, wi_reg);
        ram_wdata      = payload_word;
        ram_raddr      = srs_pkg::slot_addr(slot_reg, widx_reg);
        unit_a         = acc_reg;
        unit_b         = '0;
        unit_c         = '0;
        unit_word      = payload_word;

        unique case (state_reg)
            srs_pkg::ST_IDLE:
            begin
                if (accept && (func == srs_pkg::FUNC_MSG || func == srs_pkg::FUNC_ACK))
                begin
                    if (word_room)
                    begin
                        acc_next = unit_sum;
                        wi_next  = wi_reg + 1'b1;
                        ram_we   = (func == srs_pkg::FUNC_MSG) && tbl_stat.free_ok;
                    end
                    if (word_last && func == srs_pkg::FUNC_MSG)
                    begin
                        if (tbl_stat.free_ok)
                        begin
                            slot_next = tbl_stat.free_idx;
                        end
                        else
                        begin
                            pend_next.valid = 1'b1;
                            pend_next.kind  = srs_pkg::KIND_DROP;
                            pend_next.last  = 1'b1;
                            wi_next         = '0;
                            acc_next        = '0;
                        end
                    end
                    if (word_last && func == srs_pkg::FUNC_ACK)
                    begin
                        ack_seq_next = ack_seqnum;
                        ack_num_next = ack_number;
                        ack_chk_next = ack_checksum;
                    end
                end
                else if (accept && func == srs_pkg::FUNC_TIMEOUT)
                begin
                    off_next   = '0;
                    found_next = 1'b0;
                end
            end
            srs_pkg::ST_FILL:
            begin
                if (word_room)
                begin
                    // zero the words the message did not supply
                    ram_we    = 1'b1;
                    ram_waddr = srs_pkg::slot_addr(slot_reg, wi_reg);
                    ram_wdata = '0;
                    wi_next   = wi_reg + 1'b1;
                end
                else
                begin
                    // commit: checksum = seq - 1 + byte sum
                    unit_a         = srs_pkg::SUM_W'(next_seq_reg);
                    unit_b         = '1;
                    unit_c         = acc_reg;
                    unit_word      = '0;
                    tbl_cmd.commit = 1'b1;
                    tbl_cmd.idx    = slot_reg;
                    tbl_cmd.seq    = next_seq_reg;
                    tbl_cmd.sum    = unit_sum;
                    tstart_next    = !timer_run_reg;
                    if (!timer_run_reg)
                    begin
                        timer_run_next = 1'b1;
                        timer_seq_next = next_seq_reg;
                    end
                    next_seq_next  = (next_seq_reg == srs_pkg::SEQ_W'(srs_pkg::SEQ_SPACE - 1))
                                   ? '0 : next_seq_reg + 1'b1;
                    wi_next        = '0;
                    acc_next       = '0;
                    widx_next      = '0;
                    send_last_next = 1'b1;
                end
            end
            srs_pkg::ST_SEND:
            begin
                pend_next.valid    = 1'b1;
                pend_next.kind     = srs_pkg::KIND_SENT;
                pend_next.seq      = tbl_stat.rd_seq;
                pend_next.sum      = tbl_stat.rd_sum;
                pend_next.use_word = 1'b1;
                pend_next.last     = send_last_reg && send_done;
                pend_next.tstart   = send_last_reg && send_done && tstart_reg;
                widx_next          = widx_reg + 1'b1;
                if (send_done)
                begin
                    off_next = off_reg + 1'b1;
                end
            end
            srs_pkg::ST_SCAN:
            begin
                if (scan_hit)
                begin
                    slot_next      = tbl_stat.hit_idx;
                    widx_next      = '0;
                    send_last_next = !tbl_stat.more;
                    if (!found_reg)
                    begin
                        found_next     = 1'b1;
                        timer_run_next = 1'b1;
                        timer_seq_next = scan_seq;
                        tstart_next    = 1'b1;
                    end
                end
                else if (scan_end)
                begin
                    pend_next.valid = 1'b1;
                    pend_next.kind  = srs_pkg::KIND_NONE;
                    pend_next.last  = 1'b1;
                    timer_run_next  = 1'b0;
                end
                else
                begin
                    off_next = off_reg + 1'b1;
                end
            end
            srs_pkg::ST_ACK_CHECK:
            begin
                unit_a    = acc_reg;
                unit_b    = {{(srs_pkg::SUM_W-5){ack_seq_reg[4]}}, ack_seq_reg};
                unit_c    = {{(srs_pkg::SUM_W-5){ack_num_reg[4]}}, ack_num_reg};
                unit_word = '0;
                wi_next   = '0;
                acc_next  = '0;
                stop_next = 1'b0;
                if (ack_valid)
                begin
                    tbl_cmd.mark = 1'b1;
                    tbl_cmd.idx  = tbl_stat.hit_idx;
                    if (timer_run_reg && timer_seq_reg == ack_num_reg[3:0])
                    begin
                        timer_run_next = 1'b0;
                        stop_next      = 1'b1;
                    end
                end
                else
                begin
                    pend_next.valid     = 1'b1;
                    pend_next.kind      = srs_pkg::KIND_ACK;
                    pend_next.last      = 1'b1;
                    pend_next.corrupted = !chk_ok;
                end
            end
            srs_pkg::ST_ACK_SLIDE:
            begin
                if (tbl_stat.hit && tbl_stat.hit_acked)
                begin
                    // retire the acked packet at the base
                    tbl_cmd.clear = 1'b1;
                    tbl_cmd.idx   = tbl_stat.hit_idx;
                    base_next     = (base_reg == srs_pkg::SEQ_W'(srs_pkg::SEQ_SPACE - 1))
                                  ? '0 : base_reg + 1'b1;
                end
                else
                begin
                    pend_next.valid = 1'b1;
                    pend_next.kind  = srs_pkg::KIND_ACK;
                    pend_next.last  = 1'b1;
                    pend_next.tstop = stop_reg;
                end
            end
            default:
            begin
                pend_next = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= srs_pkg::ST_IDLE;
            wi_reg         <= '0;
            acc_reg        <= '0;
            base_reg       <= '0;
            next_seq_reg   <= '0;
            timer_run_reg  <= 1'b0;
            timer_seq_reg  <= '0;
            pend_reg       <= '0;
            out_valid      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            wi_reg         <= wi_next;
            acc_reg        <= acc_next;
            base_reg       <= base_next;
            next_seq_reg   <= next_seq_next;
            timer_run_reg  <= timer_run_next;
            timer_seq_reg  <= timer_seq_next;
            pend_reg       <= pend_next;
            out_valid      <= pend_reg.valid;
        end
    end

    // working and result payload registers
    always_ff @(posedge clk)
    begin
        slot_reg      <= slot_next;
        widx_reg      <= widx_next;
        send_last_reg <= send_last_next;
        tstart_reg    <= tstart_next;
        off_reg       <= off_next;
        found_reg     <= found_next;
        stop_reg      <= stop_next;
        ack_seq_reg   <= ack_seq_next;
        ack_num_reg   <= ack_num_next;
        ack_chk_reg   <= ack_chk_next;
        kind          <= pend_reg.kind;
        seqnum        <= pend_reg.seq;
        checksum      <= pend_reg.sum;
        out_word      <= pend_reg.use_word ? ram_rdata : '0;
        last          <= pend_reg.last;
        timer_start   <= pend_reg.tstart;
        timer_stop    <= pend_reg.tstop;
        corrupted     <= pend_reg.corrupted;
    end

    // every send cycle yields a result, registered in pend_reg and then at the outputs
    a_send_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == srs_pkg::ST_SEND |-> ##2 out_valid)
        else $error("send cycle without result");

    // status results always close their item
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != srs_pkg::KIND_SENT |-> last)
        else $error("status result not marked last");

    // a closing ack word goes to the checksum check
    a_ack_check: assert property (@(posedge clk) disable iff (!rst_n)
        accept && word_last && func == srs_pkg::FUNC_ACK |=> state_reg == srs_pkg::ST_ACK_CHECK)
        else $error("ack not checked");

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for selective_repeat_sender_unit: a directed table, then
// random messages, acks, timeouts and other codes, checked against typed rows or an in-bench model.
// ============================================================================
module tb;
    import srs_pkg::*;

    typedef struct {
        logic [1:0]         fn;
        logic [31:0]        word;
        logic               wlast;
        logic signed [4:0]  aseq;
        logic signed [4:0]  anum;
        logic signed [12:0] asum;
    } item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  seq;
        logic [12:0] sum;
        logic [31:0] word;
        logic        last;
        logic        tstart;
        logic        tstop;
        logic        cor;
    } result_t;

    // directed row: item, auto checksum for acks, optional typed expectation
    typedef struct {
        item_t   it;
        logic    fix_sum;
        logic    typed;
        result_t res;
    } row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         func = FUNC_MSG;
    logic [31:0]        payload_word = '0;
    logic               word_last = 1'b0;
    logic signed [4:0]  ack_seqnum = '0;
    logic signed [4:0]  ack_number = '0;
    logic signed [12:0] ack_checksum = '0;
    logic               out_valid;
    logic [1:0]         kind;
    logic [3:0]         seqnum;
    logic signed [12:0] checksum;
    logic [31:0]        out_word;
    logic               last;
    logic               timer_start;
    logic               timer_stop;
    logic               corrupted;

    // sender model state
    logic [31:0] pkt_store [RAM_DEPTH];
    logic [3:0]  win_seq [WINDOW_SLOTS];
    logic [12:0] win_sum [WINDOW_SLOTS];
    logic        win_sent [WINDOW_SLOTS];
    logic        win_acked [WINDOW_SLOTS];
    logic [3:0]  base_seq, tx_seq, tmr_seq;
    logic        tmr_on;
    int          widx;
    logic [12:0] acc_sum;

    result_t expected_results [$];
    int      errors = 0;
    int      cycles = 0;
    int      sent_items = 0;
    bit      allow_gaps = 1'b1;

    selective_repeat_sender_unit uut (.*);

    always #2 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 300000)
        begin
            $display("selective_repeat_sender_unit: mismatch");
            $finish;
        end
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
        errors++;
        $display("[%0t] %s: got %h expected %h", $time, what, got, exp);
    endtask

    // result checker
    always @(posedge clk)
    begin
        result_t e;
        if (out_valid)
        begin
            if (expected_results.size() == 0)
                report("unexpected result kind", 32'(kind), 32'h0);
            else
            begin
                e = expected_results.pop_front();
                if (kind !== e.kind)          report("kind", 32'(kind), 32'(e.kind));
                if (seqnum !== e.seq)         report("seqnum", 32'(seqnum), 32'(e.seq));
                if (checksum !== e.sum)       report("checksum", 32'(checksum), 32'(e.sum));
                if (out_word !== e.word)      report("out_word", out_word, e.word);
                if (last !== e.last)          report("last", 32'(last), 32'(e.last));
                if (timer_start !== e.tstart) report("timer_start", 32'(timer_start), 32'(e.tstart));
                if (timer_stop !== e.tstop)   report("timer_stop", 32'(timer_stop), 32'(e.tstop));
                if (corrupted !== e.cor)      report("corrupted", 32'(corrupted), 32'(e.cor));
            end
        end
    end

    function automatic logic [12:0] byte_total(input logic [31:0] w);
        logic [12:0] s;
        s = '0;
        for (int b = 0; b < 4; b++)
            s += 13'($signed(w[8*b +: 8]));
        return s;
    endfunction

    function automatic int slot_of(input logic [3:0] seq);
        for (int s = 0; s < WINDOW_SLOTS; s++)
            if (win_sent[s] && win_seq[s] == seq)
                return s;
        return -1;
    endfunction

    function automatic result_t status(input logic [1:0] k, input logic stop, input logic cor);
        result_t r;
        r = '0;
        r.kind = k;
        r.last = 1'b1;
        r.tstop = stop;
        r.cor = cor;
        return r;
    endfunction

    function automatic void queue_packet(input int s, ref result_t q[$]);
        result_t r;
        for (int i = 0; i < PAYLOAD_WORDS; i++)
        begin
            r = '0;
            r.kind = KIND_SENT;
            r.seq = win_seq[s];
            r.sum = win_sum[s];
            r.word = pkt_store[s*PAYLOAD_WORDS + i];
            q.push_back(r);
        end
    endfunction

    // advance the sender model by one item; returns the results it causes
    function automatic void sender_step(input item_t it, ref result_t q[$]);
        int free_s, cnt, s, b;
        logic full, any;
        logic [12:0] calc;
        logic [3:0] first, seq;
        q.delete();
        if (it.fn == FUNC_MSG)
        begin
            free_s = -1;
            cnt = 0;
            for (int i = 0; i < WINDOW_SLOTS; i++)
                if (win_sent[i]) cnt++;
                else if (free_s < 0) free_s = i;
            full = (free_s < 0) || (cnt >= SEQ_SPACE);
            if (widx < PAYLOAD_WORDS)
            begin
                acc_sum += byte_total(it.word);
                if (!full) pkt_store[free_s*PAYLOAD_WORDS + widx] = it.word;
                widx++;
            end
            if (!it.wlast) return;
            if (full)
                q.push_back(status(KIND_DROP, 1'b0, 1'b0));
            else
            begin
                for (int i = widx; i < PAYLOAD_WORDS; i++)
                    pkt_store[free_s*PAYLOAD_WORDS + i] = '0;
                win_seq[free_s] = tx_seq;
                win_sum[free_s] = 13'(tx_seq) - 13'd1 + acc_sum;
                win_sent[free_s] = 1'b1;
                win_acked[free_s] = 1'b0;
                queue_packet(free_s, q);
                q[$].last = 1'b1;
                if (!tmr_on)
                begin
                    tmr_on = 1'b1;
                    tmr_seq = tx_seq;
                    q[$].tstart = 1'b1;
                end
                tx_seq = (tx_seq == SEQ_SPACE-1) ? 4'd0 : tx_seq + 4'd1;
            end
            widx = 0;
            acc_sum = '0;
        end
        else if (it.fn == FUNC_ACK)
        begin
            if (widx < PAYLOAD_WORDS)
            begin
                acc_sum += byte_total(it.word);
                widx++;
            end
            if (!it.wlast) return;
            calc = 13'(it.aseq) + 13'(it.anum) + acc_sum;
            widx = 0;
            acc_sum = '0;
            if (calc != 13'(it.asum))
                q.push_back(status(KIND_ACK, 1'b0, 1'b1));
            else
            begin
                q.push_back(status(KIND_ACK, 1'b0, 1'b0));
                if (!it.anum[4])
                begin
                    seq = it.anum[3:0];
                    s = slot_of(seq);
                    if (s >= 0)
                    begin
                        win_acked[s] = 1'b1;
                        if (tmr_on && tmr_seq == seq)
                        begin
                            tmr_on = 1'b0;
                            q[0].tstop = 1'b1;
                        end
                        // slide over acked packets at the base
                        forever
                        begin
                            b = slot_of(base_seq);
                            if (b < 0 || !win_acked[b]) break;
                            win_sent[b] = 1'b0;
                            win_acked[b] = 1'b0;
                            base_seq = (base_seq == SEQ_SPACE-1) ? 4'd0 : base_seq + 4'd1;
                        end
                    end
                end
            end
        end
        else if (it.fn == FUNC_TIMEOUT)
        begin
            any = 1'b0;
            first = '0;
            for (int off = 0; off < SEQ_SPACE; off++)
            begin
                seq = 4'((32'(base_seq) + off) % SEQ_SPACE);
                s = slot_of(seq);
                if (s >= 0 && !win_acked[s] && q.size() + PAYLOAD_WORDS <= RAM_DEPTH)
                begin
                    if (!any) first = seq;
                    any = 1'b1;
                    queue_packet(s, q);
                end
            end
            if (!any)
            begin
                tmr_on = 1'b0;
                q.push_back(status(KIND_NONE, 1'b0, 1'b0));
            end
            else
            begin
                tmr_on = 1'b1;
                tmr_seq = first;
                q[$].last = 1'b1;
                q[$].tstart = 1'b1;
            end
        end
    endfunction

    // present one item, wait for acceptance, record its expected results
    task automatic send_item(input item_t it, input bit typed, input result_t tres);
        result_t q[$];
        start <= 1'b1;
        func <= it.fn;
        payload_word <= it.word;
        word_last <= it.wlast;
        ack_seqnum <= it.aseq;
        ack_number <= it.anum;
        ack_checksum <= it.asum;
        do @(posedge clk); while (busy);
        sender_step(it, q);
        if (typed) expected_results.push_back(tres);
        else foreach (q[i]) expected_results.push_back(q[i]);
        sent_items++;
        if (allow_gaps && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    function automatic item_t mk(input logic [1:0] fn, input logic [31:0] w, input logic wl,
                                 input logic signed [4:0] as, input logic signed [4:0] an,
                                 input logic signed [12:0] cs);
        item_t it;
        it.fn = fn; it.word = w; it.wlast = wl;
        it.aseq = as; it.anum = an; it.asum = cs;
        return it;
    endfunction

    // a whole message of 1..7 words with random content
    task automatic send_message();
        int n;
        n = $urandom_range(1, 7);
        for (int i = 0; i < n; i++)
            send_item(mk(FUNC_MSG, $urandom, i == n-1, 5'($urandom), 5'($urandom),
                         13'($urandom)), 1'b0, '0);
    endtask

    // a whole ack, mostly for an outstanding packet with a good checksum
    task automatic send_ack();
        int n;
        logic [3:0] cand [$];
        logic signed [4:0] as, an;
        logic [12:0] cs;
        logic [31:0] w;
        for (int s = 0; s < WINDOW_SLOTS; s++)
            if (win_sent[s] && !win_acked[s]) cand.push_back(win_seq[s]);
        as = 5'($signed($urandom_range(0, 12)) - 1);
        if (cand.size() > 0 && $urandom_range(0, 5) != 0)
            an = 5'(cand[$urandom_range(0, cand.size()-1)]);
        else
            an = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($signed($urandom_range(0, 12)) - 1);
        n = $urandom_range(1, 7);
        cs = 13'(as) + 13'(an) + acc_sum;
        for (int i = 0; i < n; i++)
        begin
            w = $urandom;
            // widx tracks the words already taken for this ack
            if (widx < PAYLOAD_WORDS) cs += byte_total(w);
            if (i == n-1 && $urandom_range(0, 7) == 0) cs = 13'($urandom);
            send_item(mk(FUNC_ACK, w, i == n-1, as, an, cs), 1'b0, '0);
        end
    endtask

    row_t    dir_rows [$];
    row_t    r;
    result_t none;

    function automatic row_t row(input item_t it, input logic fix, input logic typed,
                                 input result_t res);
        row_t x;
        x.it = it; x.fix_sum = fix; x.typed = typed; x.res = res;
        return x;
    endfunction

    initial
    begin
        int pick;
        none = '0;
        for (int i = 0; i < RAM_DEPTH; i++) pkt_store[i] = '0;
        for (int s = 0; s < WINDOW_SLOTS; s++)
        begin
            win_seq[s] = '0; win_sum[s] = '0; win_sent[s] = 1'b0; win_acked[s] = 1'b0;
        end
        base_seq = '0; tx_seq = '0; tmr_seq = '0; tmr_on = 1'b0; widx = 0; acc_sum = '0;

        // directed table
        dir_rows.push_back(row(mk(FUNC_TIMEOUT, 0, 1, 0, 0, 0), 0, 1,
                               status(KIND_NONE, 1'b0, 1'b0)));
        dir_rows.push_back(row(mk(FUNC_ACK, 0, 1, 0, 0, 1), 0, 1,
                               status(KIND_ACK, 1'b0, 1'b1)));
        dir_rows.push_back(row(mk(FUNC_ACK, 0, 1, -1, -1, -2), 0, 1,
                               status(KIND_ACK, 1'b0, 1'b0)));
        dir_rows.push_back(row(mk(FUNC_MSG, 32'hFFFFFFFF, 1, 0, 0, 0), 0, 0, none));
        for (int i = 0; i < 6; i++)
            dir_rows.push_back(row(mk(FUNC_MSG, (i % 2) ? 32'h80808080 : 32'h7F7F7F7F,
                                      i == 5, 0, 0, 0), 0, 0, none));
        dir_rows.push_back(row(mk(FUNC_MSG, 32'h0, 0, 0, 0, 0), 0, 0, none));
        dir_rows.push_back(row(mk(FUNC_MSG, 32'h0, 1, 0, 0, 0), 0, 0, none));
        dir_rows.push_back(row(mk(FUNC_TIMEOUT, 0, 0, 0, 0, 0), 0, 0, none));
        dir_rows.push_back(row(mk(FUNC_ACK, 32'h01020304, 1, 11, 1, 0), 1, 0, none));
        dir_rows.push_back(row(mk(FUNC_ACK, 32'hA5A5A5A5, 1, 3, 0, 0), 1, 0, none));
        // fill the window to six outstanding packets
        for (int i = 0; i < 5; i++)
            dir_rows.push_back(row(mk(FUNC_MSG, 32'h12345678 * i, 1, 0, 0, 0), 0, 0, none));
        dir_rows.push_back(row(mk(FUNC_MSG, 32'hDEADBEEF, 1, 0, 0, 0), 0, 1,
                               status(KIND_DROP, 1'b0, 1'b0)));
        // message word interrupted by an ack, then an ignored code
        dir_rows.push_back(row(mk(FUNC_MSG, 32'h11111111, 0, 0, 0, 0), 0, 0, none));
        dir_rows.push_back(row(mk(FUNC_ACK, 32'h0, 1, 0, 5'sd10, 0), 0, 0, none));
        dir_rows.push_back(row(mk(2'd3, 32'hFFFFFFFF, 1, -1, -1, -1), 0, 0, none));
        dir_rows.push_back(row(mk(FUNC_TIMEOUT, 0, 1, 0, 0, 0), 0, 0, none));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            r = dir_rows[i];
            if (r.fix_sum)
                r.it.asum = 13'(r.it.aseq) + 13'(r.it.anum) + acc_sum + byte_total(r.it.word);
            send_item(r.it, r.typed, r.res);
        end

        // random part
        while (sent_items < 300)
        begin
            if (sent_items > 250) allow_gaps = 1'b0;
            if (sent_items > 150 && sent_items < 170)
            begin
                start <= 1'b0;
                wait (expected_results.size() == 0);
                @(posedge clk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 45)
                send_message();
            else if (pick < 75)
                send_ack();
            else if (pick < 88)
                send_item(mk(FUNC_TIMEOUT, $urandom, 1'($urandom), 5'($urandom),
                             5'($urandom), 13'($urandom)), 1'b0, '0);
            else
                send_item(mk(2'($urandom), $urandom, 1'($urandom), 5'($urandom),
                             5'($urandom), 13'($urandom)), 1'b0, '0);
        end
        start <= 1'b0;

        wait (expected_results.size() == 0);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("selective_repeat_sender_unit: match");
        else
            $display("selective_repeat_sender_unit: mismatch");
        $finish;
    end
endmodule
